// File: rtl/pes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pes_pkg
// Shared widths, command and status codes for the periodic event scheduler.
// ----------------------------------------------------------------------------
package pes_pkg;

    localparam int DEF_MAX_ENTRIES = 64;
    localparam int DEF_TIME_BITS   = 40;

    localparam int CMD_W      = 2;
    localparam int ID_W       = 16;
    localparam int PER_W      = 16;
    localparam int STATUS_W   = 3;
    localparam int OUT_TIME_W = 40;

    // s_tdata: query_id, period
    localparam int S_TDATA_W = 32;
    // m_tdata: event_id, event_time, time_saturated, zero fill
    localparam int M_TDATA_W = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_NEXT  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_EVENT    = 3'd0,
        ST_ADDED    = 3'd1,
        ST_CLEARED  = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_REJECTED = 3'd4
    } status_t;

endpackage

// File: rtl/pes_heap_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pes_heap_ram
// Heap storage: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module pes_heap_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 72
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr_a,
    output logic [DATA_W-1:0] rd_data_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [DATA_W-1:0] rd_data_b
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// File: rtl/periodic_event_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_event_scheduler
// Min-heap of periodic queries keyed by {fire time, id, period}; add inserts,
// next pops the earliest, reports it and reinserts it one period later.
//
//  channel  dir  ports                        word
//  s_       in   s_tvalid s_tready s_t*       tuser command, tdata id/period
//  m_       out  m_tvalid m_tready m_t*       tuser status, tdata event
//
// one word is processed at a time; s_tready is high only while idle
// clear and rejected words go straight to the finish state; add writes at
// the root, or else climbs with one parent read and one key compare per
// level; next waits for the root read, then descends with one read of both
// children and one key compare per level
// the result waits in an output register, so a stalled m_ side only holds
// back the word after next; reset clears count and started, no ram sweep
// ----------------------------------------------------------------------------
module periodic_event_scheduler
    import pes_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int TIME_BITS   = DEF_TIME_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // query_id[15:0], period[31:16]
    input  logic [CMD_W-1:0]     s_tuser,   // command[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // event_id[15:0], event_time[55:16],
                                            // time_saturated[56], zero[63:57]
    output logic [STATUS_W-1:0]  m_tuser    // status[2:0]
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CH_W  = IDX_W + 2;
    // key ordering: time in the top bits, then id, then period
    localparam int ENT_W = TIME_BITS + ID_W + PER_W;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_UP_RD    = 8'b0000_0010,
        S_UP_CMP   = 8'b0000_0100,
        S_TOP_WAIT = 8'b0000_1000,
        S_DN_RD    = 8'b0001_0000,
        S_DN_CMP   = 8'b0010_0000,
        S_FINISH   = 8'b0100_0000,
        S_SPARE    = 8'b1000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 started_reg, started_next;
    logic [IDX_W-1:0]     pos_reg, pos_next;
    logic [ENT_W-1:0]     mov_reg, mov_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [ID_W-1:0]      res_id_reg, res_id_next;
    logic [OUT_TIME_W-1:0] res_time_reg, res_time_next;
    logic                 res_sat_reg, res_sat_next;
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic [STATUS_W-1:0]  m_user_reg, m_user_next;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr, rd_addr_a, rd_addr_b;
    logic [ENT_W-1:0]     wr_data, rd_data_a, rd_data_b;

    logic [ID_W-1:0]      in_id;
    logic [PER_W-1:0]     in_per;
    logic [CMD_W-1:0]     in_cmd;
    logic                 accept;

    logic [IDX_W-1:0]     parent;
    logic [CH_W-1:0]      left_idx, right_idx, count_ext;
    logic                 left_ok, right_ok;

    logic [TIME_BITS-1:0] top_time;
    logic [PER_W-1:0]     top_per;
    logic [TIME_BITS:0]   time_sum;
    logic [OUT_TIME_W+TIME_BITS-1:0] time_wide;

    logic [ENT_W-1:0]     best;
    logic [IDX_W-1:0]     best_idx;
    logic                 best_moved;

    pes_heap_ram #(
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (IDX_W),
        .DATA_W (ENT_W)
    ) u_ram (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

    assign in_id  = s_tdata[ID_W-1:0];
    assign in_per = s_tdata[ID_W+PER_W-1:ID_W];
    assign in_cmd = s_tuser;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    assign parent    = IDX_W'((pos_reg - IDX_W'(1)) >> 1);
    assign left_idx  = {1'b0, pos_reg, 1'b1};
    assign right_idx = left_idx + CH_W'(1);
    assign count_ext = CH_W'(count_reg);
    assign left_ok   = left_idx < count_ext;
    assign right_ok  = right_idx < count_ext;

    // popped entry: fields of the root as read
    assign top_time  = rd_data_a[ENT_W-1:ID_W+PER_W];
    assign top_per   = rd_data_a[PER_W-1:0];
    assign time_sum  = {1'b0, top_time} + (TIME_BITS+1)'(top_per);
    assign time_wide = {{OUT_TIME_W{1'b0}}, top_time};

    // pick the smallest of the moving entry and the children in range
    always_comb begin
        best       = mov_reg;
        best_idx   = pos_reg;
        best_moved = 1'b0;
        if (left_ok && (rd_data_a < best)) begin
            best       = rd_data_a;
            best_idx   = left_idx[IDX_W-1:0];
            best_moved = 1'b1;
        end
        if (right_ok && (rd_data_b < best)) begin
            best       = rd_data_b;
            best_idx   = right_idx[IDX_W-1:0];
            best_moved = 1'b1;
        end
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        started_next    = started_reg;
        pos_next        = pos_reg;
        mov_next        = mov_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_time_next   = res_time_reg;
        res_sat_next    = res_sat_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        wr_en           = 1'b0;
        wr_addr         = pos_reg;
        wr_data         = mov_reg;
        rd_addr_a       = parent;
        rd_addr_b       = parent;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                rd_addr_a = '0;
                if (accept) begin
                    res_status_next = ST_REJECTED;
                    res_id_next     = '0;
                    res_time_next   = '0;
                    res_sat_next    = 1'b0;
                    state_next      = S_FINISH;
                    case (in_cmd)
                        CMD_ADD: begin
                            if (!started_reg && (count_reg < CNT_W'(MAX_ENTRIES))) begin
                                mov_next        = {TIME_BITS'(in_per), in_id, in_per};
                                pos_next        = count_reg[IDX_W-1:0];
                                count_next      = count_reg + CNT_W'(1);
                                res_status_next = ST_ADDED;
                                state_next      = S_UP_RD;
                            end
                        end
                        CMD_NEXT: begin
                            if (count_reg == '0) begin
                                res_status_next = ST_EMPTY;
                            end else begin
                                state_next = S_TOP_WAIT;
                            end
                        end
                        CMD_CLEAR: begin
                            count_next      = '0;
                            started_next    = 1'b0;
                            res_status_next = ST_CLEARED;
                        end
                        default: begin
                            res_status_next = ST_REJECTED;
                        end
                    endcase
                end
            end
            S_UP_RD: begin
                if (pos_reg == '0) begin
                    wr_en      = 1'b1;
                    state_next = S_FINISH;
                end else begin
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                wr_en = 1'b1;
                if (mov_reg < rd_data_a) begin
                    wr_data    = rd_data_a;
                    pos_next   = parent;
                    state_next = S_UP_RD;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_TOP_WAIT: begin
                res_status_next = ST_EVENT;
                res_id_next     = rd_data_a[ID_W+PER_W-1:PER_W];
                res_time_next   = time_wide[OUT_TIME_W-1:0];
                res_sat_next    = time_sum[TIME_BITS];
                started_next    = 1'b1;
                pos_next        = '0;
                if (time_sum[TIME_BITS]) begin
                    mov_next = {{TIME_BITS{1'b1}}, rd_data_a[ID_W+PER_W-1:0]};
                end else begin
                    mov_next = {time_sum[TIME_BITS-1:0], rd_data_a[ID_W+PER_W-1:0]};
                end
                state_next = S_DN_RD;
            end
            S_DN_RD: begin
                rd_addr_a  = left_idx[IDX_W-1:0];
                rd_addr_b  = right_idx[IDX_W-1:0];
                state_next = S_DN_CMP;
            end
            S_DN_CMP: begin
                wr_en = 1'b1;
                if (best_moved) begin
                    wr_data    = best;
                    pos_next   = best_idx;
                    state_next = S_DN_RD;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_user_next  = res_status_reg;
                    m_data_next  = M_TDATA_W'({res_sat_reg, res_time_reg, res_id_reg});
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            started_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            started_reg <= started_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg        <= pos_next;
        mov_reg        <= mov_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_time_reg   <= res_time_next;
        res_sat_reg    <= res_sat_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
    end

endmodule
